FILE: rtl/adaptive_mean_threshold_binarizer_top_assert.svh
// Assertion macros shared by the checker.
`ifndef ADAPTIVE_MEAN_THRESHOLD_BINARIZER_TOP_ASSERT_SVH
`define ADAPTIVE_MEAN_THRESHOLD_BINARIZER_TOP_ASSERT_SVH

// Checked only while reset is released.
`define AMTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amtb assertion failed");

// Checked at every edge, reset included.
`define AMTB_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("amtb assertion failed");

`endif

FILE: rtl/amtb_pkg.sv
package amtb_pkg;

  localparam int CRD_W  = 12;
  localparam int SIZE_W = 13;
  localparam int SLOT_W = 4;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [7:0]  OFFSET_RST = 8'd15;

  localparam logic [7:0] GRAY_R_COEF = 8'd77;
  localparam logic [7:0] GRAY_G_COEF = 8'd150;
  localparam logic [7:0] GRAY_B_COEF = 8'd29;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_IMAGE_HEIGHT     = 2'd1,
    REG_THRESHOLD_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       is_white;
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [7:0]        gray;
    logic [CRD_W-1:0]  col;
    logic [CRD_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              col_last;
    logic              row_last;
  } job_t;

endpackage

FILE: rtl/amtb_ram.sv
module amtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/amtb_fifo.sv
module amtb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/amtb_front.sv
module amtb_front import amtb_pkg::*; #(
  parameter int RADIUS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  pixel_t            pixel,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  input  logic              restart,
  output logic              job_push,
  output job_t              job
);

  localparam int WIN = 2 * RADIUS + 1;

  logic [CRD_W-1:0]  col_r, col_nxt;
  logic [CRD_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [15:0]       gray_sum;
  logic              col_last, row_last;

  assign gray_sum = 16'(pixel.red * GRAY_R_COEF) + 16'(pixel.green * GRAY_G_COEF)
                  + 16'(pixel.blue * GRAY_B_COEF);
  assign col_last = ({1'b0, col_r} == width - 1'b1);
  assign row_last = ({1'b0, row_r} == height - 1'b1);

  assign job_push     = accept;
  assign job.gray     = gray_sum[15:8];
  assign job.col      = col_r;
  assign job.row      = row_r;
  assign job.slot     = slot_r;
  assign job.col_last = col_last;
  assign job.row_last = row_last;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = (slot_r == SLOT_W'(WIN - 1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

FILE: rtl/amtb_back.sv
module amtb_back import amtb_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_empty,
  output logic              job_pop,
  input  job_t              job,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  input  logic [7:0]        offset,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res
);

  localparam int WIN   = 2 * RADIUS + 1;
  localparam int DEPTH = WIN * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam logic [CRD_W-1:0] RC = CRD_W'(RADIUS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WINS = 6'b000010,
    ST_READ = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_CMP  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CRD_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [CRD_W-1:0]  xlo_r, xlo_nxt, xhi_r, xhi_nxt, yhi_r, yhi_nxt;
  logic [CRD_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [CRD_W-1:0]  x1_r, x1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [CRD_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        g_r, g_nxt;
  logic [3:0]        dcnt_r, dcnt_nxt;
  logic              rdv_r, rdv_nxt, ctr_r, ctr_nxt;

  logic [CRD_W-1:0]  j_xlo, j_xhi, j_ylo, j_yhi;
  logic              j_xany, j_yany;
  logic [CRD_W-1:0]  w_x1, w_x2, w_y1, w_y2;
  logic [CRD_W:0]    w_x2t, w_y2t;
  logic [3:0]        w_xn, w_yn;
  logic [3:0]        rd_dist;
  logic [SLOT_W-1:0] rd_slot;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic [8:0]        div_try;
  logic              res_last;

  amtb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (job.gray),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    j_xany = job.col_last || (job.col >= RC);
    j_xhi  = job.col_last ? job.col : job.col - RC;
    j_xlo  = (job.col >= RC) ? job.col - RC : '0;
    j_yany = job.row_last || (job.row >= RC);
    j_yhi  = job.row_last ? job.row : job.row - RC;
    j_ylo  = (job.row >= RC) ? job.row - RC : '0;

    w_x1  = (ox_r >= RC) ? ox_r - RC : '0;
    w_y1  = (oy_r >= RC) ? oy_r - RC : '0;
    w_x2t = {1'b0, ox_r} + {1'b0, RC};
    w_y2t = {1'b0, oy_r} + {1'b0, RC};
    w_x2  = (w_x2t > width - 1'b1) ? CRD_W'(width - 1'b1) : CRD_W'(w_x2t);
    w_y2  = (w_y2t > height - 1'b1) ? CRD_W'(height - 1'b1) : CRD_W'(w_y2t);
    w_xn  = 4'(w_x2 - w_x1 + 1'b1);
    w_yn  = 4'(w_y2 - w_y1 + 1'b1);

    rd_dist = 4'(row_r - y_r);
    rd_slot = (slot_r >= rd_dist) ? slot_r - rd_dist
                                  : SLOT_W'(5'(slot_r) + 5'(WIN) - 5'(rd_dist));
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(x_r[XW-1:0]);
    wr_addr = AW'(job.slot) * AW'(MAX_WIDTH) + AW'(job.col[XW-1:0]);

    div_try  = {rem_r[7:0], sum_r[15]};
    res_last = (ox_r == xhi_r) && (oy_r == yhi_r);

    res.is_white    = (16'({1'b0, g_r}) + 16'(offset)) > sum_r;
    res.out_x       = ox_r[9:0];
    res.out_y       = oy_r[9:0];
    res.last_of_run = res_last;
  end

  always_comb begin
    state_nxt = state_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    xlo_nxt   = xlo_r;
    xhi_nxt   = xhi_r;
    yhi_nxt   = yhi_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    x1_nxt    = x1_r;
    x2_nxt    = x2_r;
    y2_nxt    = y2_r;
    row_nxt   = row_r;
    slot_nxt  = slot_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    g_nxt     = g_r;
    dcnt_nxt  = dcnt_r;
    rdv_nxt   = 1'b0;
    ctr_nxt   = 1'b0;
    job_pop   = 1'b0;
    wr_en     = 1'b0;
    res_push  = 1'b0;

    if (rdv_r) begin
      sum_nxt = sum_r + 16'(rd_data);
      if (ctr_r) begin
        g_nxt = rd_data;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          wr_en    = 1'b1;
          row_nxt  = job.row;
          slot_nxt = job.slot;
          ox_nxt   = j_xlo;
          oy_nxt   = j_ylo;
          xlo_nxt  = j_xlo;
          xhi_nxt  = j_xhi;
          yhi_nxt  = j_yhi;
          if (j_xany && j_yany) begin
            state_nxt = ST_WINS;
          end
        end
      end
      ST_WINS: begin
        x_nxt     = w_x1;
        y_nxt     = w_y1;
        x1_nxt    = w_x1;
        x2_nxt    = w_x2;
        y2_nxt    = w_y2;
        cnt_nxt   = 8'(w_xn) * 8'(w_yn);
        sum_nxt   = '0;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        rdv_nxt = 1'b1;
        ctr_nxt = (x_r == ox_r) && (y_r == oy_r);
        if (x_r == x2_r) begin
          x_nxt = x1_r;
          if (y_r == y2_r) begin
            state_nxt = ST_WAIT;
          end else begin
            y_nxt = y_r + 1'b1;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_WAIT: begin
        rem_nxt   = '0;
        dcnt_nxt  = 4'd15;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_try >= {1'b0, cnt_r}) begin
          rem_nxt = div_try - {1'b0, cnt_r};
          sum_nxt = {sum_r[14:0], 1'b1};
        end else begin
          rem_nxt = div_try;
          sum_nxt = {sum_r[14:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (res_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WINS;
            if (ox_r == xhi_r) begin
              ox_nxt = xlo_r;
              oy_nxt = oy_r + 1'b1;
            end else begin
              ox_nxt = ox_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      ctr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      ctr_r   <= ctr_nxt;
    end
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    xlo_r  <= xlo_nxt;
    xhi_r  <= xhi_nxt;
    yhi_r  <= yhi_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    x1_r   <= x1_nxt;
    x2_r   <= x2_nxt;
    y2_r   <= y2_nxt;
    row_r  <= row_nxt;
    slot_r <= slot_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    g_r    <= g_nxt;
    dcnt_r <= dcnt_nxt;
  end

endmodule

FILE: rtl/adaptive_mean_threshold_binarizer_top.sv
// Streaming adaptive mean threshold binarizer with a box window.
// Input: raster RGB pixels, pushed with in_push while in_full is low.
// Output: one beat per binarized pixel with its coordinates, read with out_pop
// while out_empty is low; last_of_run marks the final beat caused by one input.
// Configuration: cfg_valid/cfg_ready write image width, height and offset.
// cfg_ready is always high; a size write restarts the frame at pixel zero.
// Each pixel is converted to gray combinationally and pushed into the pixel queue;
// the window engine then stores it and produces results one at a time. A pixel
// that causes no result leaves the engine once it is popped and stored in
// ST_IDLE. For each result the engine passes through ST_WINS, ST_READ, ST_WAIT,
// ST_DIV and ST_CMP: it reads the n window pixels (n at most (2*RADIUS+1)^2)
// through the single read port of the line store, and takes the mean with a
// restoring divide.
// Reset returns the counters to the first pixel and the registers to
// 640 x 480 with offset 15; the line store is not cleared.
// When the receiver stalls, the result queue fills, the engine waits, then
// the pixel queue fills and in_full rises.
module adaptive_mean_threshold_binarizer_top import amtb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int RADIUS     = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  pixel_t      in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [10:0]       width_r, width_nxt;
  logic [10:0]       height_r, height_nxt;
  logic [7:0]        offset_r, offset_nxt;
  logic              restart;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic              job_push, job_pop, job_full, job_empty;
  job_t              job_in, job_out;
  logic              res_push, res_full;
  result_t           res;
  logic [$bits(result_t)-1:0] out_vec;
  logic [$bits(job_t)-1:0]    job_vec;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    offset_nxt = offset_r;
    restart    = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        REG_THRESHOLD_OFFSET: begin
          offset_nxt = cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      offset_r <= OFFSET_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_comb begin
    if (width_r == '0) begin
      width_eff = SIZE_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = SIZE_W'(width_r);
    end
    if (height_r == '0) begin
      height_eff = SIZE_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = SIZE_W'(height_r);
    end
  end

  amtb_front #(.RADIUS(RADIUS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_push && !in_full),
    .pixel    (in_data),
    .width    (width_eff),
    .height   (height_eff),
    .restart  (restart),
    .job_push (job_push),
    .job      (job_in)
  );

  amtb_fifo #(.WIDTH($bits(job_t)), .DEPTH(4)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_vec),
    .empty (job_empty)
  );

  assign in_full = job_full;
  assign job_out = job_t'(job_vec);

  amtb_back #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .width     (width_eff),
    .height    (height_eff),
    .offset    (offset_r),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  amtb_fifo #(.WIDTH($bits(result_t)), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_vec),
    .empty (out_empty)
  );

  assign out_data = result_t'(out_vec);

endmodule

FILE: rtl/amtb_checker.sv
`include "adaptive_mean_threshold_binarizer_top_assert.svh"

module amtb_checker import amtb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input result_t     out_data
);

  // After reset both queues are empty.
  `AMTB_ASSERT_NEXT_ANY(a_reset_empty, clk, !rst_n, out_empty && !in_full)

  // No result appears before a pixel has been taken.
  `AMTB_ASSERT_NEXT_ANY(a_no_early_beat, clk, !rst_n ##1 (rst_n && !in_push), out_empty)

  // A waiting beat stays until it is popped.
  `AMTB_ASSERT_NEXT(a_beat_held, clk, rst_n, !out_empty && !out_pop, !out_empty)

  `AMTB_ASSERT_NEXT(a_beat_stable, clk, rst_n, !out_empty && !out_pop, $stable(out_data))

endmodule

bind adaptive_mean_threshold_binarizer_top amtb_checker u_amtb_checker (.*);
